### hw/rtl/xmleu_pkg.sv
`default_nettype none

package xmleu_pkg;

  localparam int HoldDepth = 7;
  localparam int EmitMax   = 8;
  localparam int NumEnt    = 5;
  localparam int NameMax   = 5;
  localparam int NumW      = 17;

  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChSemi   = 8'h3b;

  // entity names without the leading ampersand, semicolon included
  localparam logic [7:0] EntName [NumEnt][NameMax] = '{
    '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
    '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b}
  };
  localparam logic [2:0] EntLen  [NumEnt] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam logic [7:0] EntChar [NumEnt] = '{8'h3c, 8'h3e, 8'h26, 8'h27, 8'h22};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_AMP,
    PH_NAME,
    PH_HASH,
    PH_DEC,
    PH_HEXMARK,
    PH_HEX
  } phase_e;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_MISS,
    ACT_CHAR,
    ACT_NUM,
    ACT_BIG
  } act_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_last;
  } xmleu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_end;
    logic       text_end;
  } xmleu_out_t;

  typedef struct packed {
    logic [EmitMax-1:0][7:0] bytes;
    logic [3:0]              count;
  } xmleu_emit_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/xml_entity_unescape.sv
`default_nettype none

// channel   direction  handshake                 word
// in        input      in_valid_i / in_stall_o   text_byte, stream_last
// out       output     out_valid_o / out_stall_i out_byte, byte_present, run_end, text_end
//
// a byte enters an input register, is decoded against the open match and its words land
// in an eight-word output buffer that drains one word per cycle while out_stall_i is low
// a byte that yields at most one word sustains one byte per cycle unless out_stall_i is set;
// a byte that yields more holds the output buffer until all drain, the port being the limit
// bytes that yield no word pass the decoder even while the buffer drains
// reset clears the match state and both valid flags; no clearing pass is needed

module xml_entity_unescape #(
  parameter int MAX_DEC_DIGITS = 5,
  parameter int MAX_HEX_DIGITS = 4
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  xmleu_pkg::xmleu_in_t    in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output xmleu_pkg::xmleu_out_t   out_data_o
);
  import xmleu_pkg::*;

  logic                    in_valid_q;
  xmleu_in_t               in_q;
  xmleu_emit_t             emit;

  logic [EmitMax-1:0][7:0] buf_q;
  logic [3:0]              cnt_q;
  logic [2:0]              idx_q;
  logic                    busy_q;
  logic                    last_q;
  logic                    present_q;

  logic                    in_acc;
  logic                    out_acc;
  logic                    run_end;
  logic                    buf_free;
  logic                    need_buf;
  logic                    adv;

  xmleu_decode #(
    .MAX_DEC_DIGITS(MAX_DEC_DIGITS),
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
  ) u_decode (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(adv),
    .in_i  (in_q),
    .emit_o(emit)
  );

  assign run_end  = {1'b0, idx_q} == 4'(cnt_q - 4'd1);
  assign out_acc  = busy_q && !out_stall_i;
  assign buf_free = !busy_q || (out_acc && run_end);
  assign need_buf = (emit.count != 4'd0) || in_q.stream_last;
  assign adv      = in_valid_q && (buf_free || !need_buf);

  assign in_stall_o = in_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o             = busy_q;
  assign out_data_o.out_byte     = present_q ? buf_q[idx_q] : 8'h00;
  assign out_data_o.byte_present = present_q;
  assign out_data_o.run_end      = run_end;
  assign out_data_o.text_end     = run_end && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      busy_q     <= 1'b0;
      cnt_q      <= 4'd0;
      idx_q      <= 3'd0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv && need_buf) begin
        busy_q <= 1'b1;
        cnt_q  <= (emit.count == 4'd0) ? 4'd1 : emit.count;
        idx_q  <= 3'd0;
      end else if (out_acc && run_end) begin
        busy_q <= 1'b0;
      end else if (out_acc) begin
        idx_q <= 3'(idx_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (adv && need_buf) begin
      buf_q     <= emit.bytes;
      last_q    <= in_q.stream_last;
      present_q <= emit.count != 4'd0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/xmleu_decode.sv
`default_nettype none

module xmleu_decode #(
  parameter int MAX_DEC_DIGITS = 5,
  parameter int MAX_HEX_DIGITS = 4
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     step_i,
  input  xmleu_pkg::xmleu_in_t    in_i,
  output xmleu_pkg::xmleu_emit_t  emit_o
);
  import xmleu_pkg::*;

  localparam int MaxDigits = (MAX_DEC_DIGITS > MAX_HEX_DIGITS) ? MAX_DEC_DIGITS : MAX_HEX_DIGITS;
  localparam int DigW      = $clog2(MaxDigits + 1);

  logic [7:0]      held_q [HoldDepth];
  logic [2:0]      hc_q, hc_d;
  phase_e          phase_q, phase_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DigW-1:0] dc_q, dc_d;

  logic [7:0]      c;
  logic            last;
  logic            is_dig;
  logic [4:0]      hv;
  logic            can_hold;
  logic [2:0]      k;
  logic            name_hit;
  logic [2:0]      name_idx;
  logic            name_ok;
  logic            name_cmp;
  act_e            act;
  phase_e          hold_ph;
  logic [NumW-1:0] hold_num;
  logic [DigW-1:0] hold_dc;
  logic [7:0]      chr;
  logic [NumW-1:0] dec_next;

  logic            wr_en;
  logic [2:0]      wr_addr;

  logic            pfx;
  logic [3:0][7:0] tail;
  logic [1:0]      tn;
  logic [2:0]      pn;
  logic [2:0]      off;
  logic [15:0]     v;

  assign c        = in_i.text_byte;
  assign last     = in_i.stream_last;
  assign is_dig   = (c >= 8'h30) && (c <= 8'h39);
  assign hv       = hex_val(c);
  assign can_hold = hc_q < 3'(HoldDepth);
  assign k        = (hc_q != 3'd0) ? 3'(hc_q - 3'd1) : 3'd0;
  assign dec_next = {num_q[NumW-4:0], 3'b000} + {num_q[NumW-2:0], 1'b0}
                  + {{(NumW-4){1'b0}}, c[3:0]};
  assign v        = num_q[15:0];

  // entity name search
  always_comb begin
    name_hit = 1'b0;
    name_idx = 3'd0;
    name_ok  = 1'b0;
    name_cmp = 1'b0;
    for (int i = 0; i < NumEnt; i++) begin
      name_ok  = k < EntLen[i];
      name_cmp = 1'b0;
      for (int j = 0; j < NameMax; j++) begin
        if (3'(j) < k && held_q[j+1] != EntName[i][j]) begin
          name_ok = 1'b0;
        end
        if (3'(j) == k && EntName[i][j] == c) begin
          name_cmp = 1'b1;
        end
      end
      if (name_ok && name_cmp && !name_hit) begin
        name_hit = 1'b1;
        name_idx = 3'(i);
      end
    end
  end

  // classify the byte against the open match
  always_comb begin
    act      = ACT_MISS;
    hold_ph  = PH_IDLE;
    hold_num = num_q;
    hold_dc  = dc_q;
    chr      = 8'h00;
    unique case (phase_q)
      PH_IDLE: begin
        if (c == ChAmp) begin
          act     = ACT_HOLD;
          hold_ph = PH_AMP;
        end
      end
      PH_AMP, PH_NAME: begin
        if (phase_q == PH_AMP && c == ChHash) begin
          act     = ACT_HOLD;
          hold_ph = PH_HASH;
        end else if (name_hit) begin
          if (hc_q == EntLen[name_idx]) begin
            act = ACT_CHAR;
            chr = EntChar[name_idx];
          end else if (can_hold) begin
            act     = ACT_HOLD;
            hold_ph = PH_NAME;
          end
        end
      end
      PH_HASH: begin
        if (is_dig) begin
          act      = ACT_HOLD;
          hold_ph  = PH_DEC;
          hold_num = {{(NumW-4){1'b0}}, c[3:0]};
          hold_dc  = DigW'(1);
        end else if (c == ChLowerX) begin
          act     = ACT_HOLD;
          hold_ph = PH_HEXMARK;
        end
      end
      PH_DEC: begin
        if (is_dig && dc_q < DigW'(MAX_DEC_DIGITS) && can_hold) begin
          act      = ACT_HOLD;
          hold_ph  = PH_DEC;
          hold_num = dec_next;
          hold_dc  = DigW'(dc_q + 1'b1);
        end else if (c == ChSemi) begin
          act = num_q[NumW-1] ? ACT_BIG : ACT_NUM;
        end
      end
      PH_HEXMARK: begin
        if (hv[4] && can_hold) begin
          act      = ACT_HOLD;
          hold_ph  = PH_HEX;
          hold_num = {{(NumW-4){1'b0}}, hv[3:0]};
          hold_dc  = DigW'(1);
        end
      end
      PH_HEX: begin
        if (hv[4] && dc_q < DigW'(MAX_HEX_DIGITS) && can_hold) begin
          act      = ACT_HOLD;
          hold_ph  = PH_HEX;
          hold_num = {num_q[NumW-5:0], hv[3:0]};
          hold_dc  = DigW'(dc_q + 1'b1);
        end else if (c == ChSemi) begin
          act = ACT_NUM;
        end
      end
      default: begin
        act = ACT_MISS;
      end
    endcase
  end

  // next match state
  always_comb begin
    hc_d    = hc_q;
    phase_d = phase_q;
    num_d   = num_q;
    dc_d    = dc_q;
    wr_en   = 1'b0;
    wr_addr = hc_q;
    if (step_i) begin
      hc_d    = 3'd0;
      phase_d = PH_IDLE;
      num_d   = '0;
      dc_d    = '0;
      if (!last) begin
        unique case (act)
          ACT_HOLD: begin
            wr_en   = 1'b1;
            hc_d    = 3'(hc_q + 3'd1);
            phase_d = hold_ph;
            num_d   = hold_num;
            dc_d    = hold_dc;
          end
          ACT_MISS: begin
            if (c == ChAmp) begin
              wr_en   = 1'b1;
              wr_addr = 3'd0;
              hc_d    = 3'd1;
              phase_d = PH_AMP;
            end
          end
          ACT_CHAR, ACT_NUM, ACT_BIG: begin
            hc_d = 3'd0;
          end
          default: begin
            hc_d = 3'd0;
          end
        endcase
      end
    end
  end

  // emitted words: held prefix, then up to three tail bytes
  always_comb begin
    pfx  = 1'b0;
    tail = '0;
    tn   = 2'd0;
    unique case (act)
      ACT_HOLD: begin
        if (last) begin
          pfx     = 1'b1;
          tail[0] = c;
          tn      = 2'd1;
        end
      end
      ACT_MISS: begin
        pfx = 1'b1;
        if (c != ChAmp || last) begin
          tail[0] = c;
          tn      = 2'd1;
        end
      end
      ACT_CHAR: begin
        tail[0] = chr;
        tn      = 2'd1;
      end
      ACT_NUM: begin
        if (v == 16'd0) begin
          tn = 2'd0;
        end else if (v < 16'h0080) begin
          tail[0] = v[7:0];
          tn      = 2'd1;
        end else if (v < 16'h0800) begin
          tail[0] = {3'b110, v[10:6]};
          tail[1] = {2'b10, v[5:0]};
          tn      = 2'd2;
        end else begin
          tail[0] = {4'b1110, v[15:12]};
          tail[1] = {2'b10, v[11:6]};
          tail[2] = {2'b10, v[5:0]};
          tn      = 2'd3;
        end
      end
      ACT_BIG: begin
        pfx     = 1'b1;
        tail[0] = ChSemi;
        tn      = 2'd1;
      end
      default: begin
        pfx = 1'b0;
      end
    endcase
  end

  assign pn = pfx ? hc_q : 3'd0;

  always_comb begin
    emit_o.count = 4'({1'b0, pn} + {2'b00, tn});
    off          = 3'd0;
    for (int i = 0; i < EmitMax; i++) begin
      off             = 3'(3'(i) - pn);
      emit_o.bytes[i] = tail[off[1:0]];
    end
    for (int i = 0; i < HoldDepth; i++) begin
      if (3'(i) < pn) begin
        emit_o.bytes[i] = held_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q    <= 3'd0;
      phase_q <= PH_IDLE;
      num_q   <= '0;
      dc_q    <= '0;
    end else begin
      hc_q    <= hc_d;
      phase_q <= phase_d;
      num_q   <= num_d;
      dc_q    <= dc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      held_q[wr_addr] <= c;
    end
  end

endmodule

`default_nettype wire

### test/tb_top.sv
module tb_top;
  import xmleu_pkg::*;

  localparam int MaxDec     = 5;
  localparam int MaxHex     = 4;
  localparam int NumRandom  = 200;
  localparam int CycleLimit = 1000000;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  xmleu_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  xmleu_out_t out_data;

  xml_entity_unescape #(
    .MAX_DEC_DIGITS(MaxDec),
    .MAX_HEX_DIGITS(MaxHex)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // decoder state mirror
  string      ent_names [5] = '{"lt;", "gt;", "amp;", "apos;", "quot;"};
  logic [7:0] ent_chars [5] = '{"<", ">", "&", "'", "\""};
  logic [7:0] held [HoldDepth];
  int         held_n;
  phase_e     phase;
  logic [16:0] num_val;
  int         dig_n;
  logic [7:0] emit_b [$];

  xmleu_out_t  decoded_q [$];
  xmleu_in_t   text_q [$];
  logic [7:0]  frag [$];

  int in_gap, in_burst, stall_left, out_burst;
  int n_bytes, n_words, n_texts, n_errors;
  int unsigned n_cycles;

  function automatic void put_byte(logic [7:0] b);
    if (emit_b.size() < EmitMax) emit_b.push_back(b);
  endfunction

  function automatic void release_held();
    for (int i = 0; i < held_n; i++) put_byte(held[i]);
    held_n = 0;
  endfunction

  function automatic void drop_match();
    held_n = 0;
    phase = PH_IDLE;
    num_val = '0;
    dig_n = 0;
  endfunction

  function automatic void hold_byte(logic [7:0] c);
    if (held_n < HoldDepth) begin
      held[held_n] = c;
      held_n++;
    end
  endfunction

  function automatic void put_utf8(logic [16:0] v);
    logic [15:0] u;
    u = v[15:0];
    if (u == 16'h0000) return;
    if (u < 16'h0080) begin
      put_byte(u[7:0]);
    end else if (u < 16'h0800) begin
      put_byte({3'b110, u[10:6]});
      put_byte({2'b10, u[5:0]});
    end else begin
      put_byte({4'b1110, u[15:12]});
      put_byte({2'b10, u[11:6]});
      put_byte({2'b10, u[5:0]});
    end
  endfunction

  function automatic void miss(logic [7:0] c);
    release_held();
    drop_match();
    if (c == ChAmp) begin
      hold_byte(c);
      phase = PH_AMP;
    end else begin
      put_byte(c);
    end
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // entity name that the held bytes plus c still continue
  function automatic int name_hit(logic [7:0] c);
    int k;
    bit ok;
    k = (held_n > 0) ? held_n - 1 : 0;
    for (int i = 0; i < 5; i++) begin
      if (k >= ent_names[i].len()) continue;
      ok = 1'b1;
      for (int j = 0; j < k; j++) begin
        if (held[j + 1] != ent_names[i][j]) ok = 1'b0;
      end
      if (ok && ent_names[i][k] == c) return i;
    end
    return -1;
  endfunction

  function automatic void take_byte(logic [7:0] c);
    int d;
    int n;
    logic [16:0] v;
    d = hex_digit(c);
    case (phase)
      PH_IDLE: begin
        if (c == ChAmp) begin
          hold_byte(c);
          phase = PH_AMP;
        end else begin
          put_byte(c);
        end
      end
      PH_AMP, PH_NAME: begin
        if (phase == PH_AMP && c == ChHash) begin
          hold_byte(c);
          phase = PH_HASH;
        end else begin
          n = name_hit(c);
          if (n < 0) begin
            miss(c);
          end else if (held_n == ent_names[n].len()) begin
            drop_match();
            put_byte(ent_chars[n]);
          end else if (held_n < HoldDepth) begin
            hold_byte(c);
            phase = PH_NAME;
          end else begin
            miss(c);
          end
        end
      end
      PH_HASH: begin
        if (c >= "0" && c <= "9") begin
          hold_byte(c);
          phase = PH_DEC;
          num_val = 17'(c - "0");
          dig_n = 1;
        end else if (c == ChLowerX) begin
          hold_byte(c);
          phase = PH_HEXMARK;
        end else begin
          miss(c);
        end
      end
      PH_DEC: begin
        if (c >= "0" && c <= "9" && dig_n < MaxDec && held_n < HoldDepth) begin
          hold_byte(c);
          num_val = 17'(num_val * 10 + (c - "0"));
          dig_n++;
        end else if (c == ChSemi) begin
          if (num_val > 17'h0FFFF) begin
            // out of range, reference goes out as plain text
            release_held();
            put_byte(c);
            drop_match();
          end else begin
            v = num_val;
            drop_match();
            put_utf8(v);
          end
        end else begin
          miss(c);
        end
      end
      PH_HEXMARK: begin
        if (d >= 0 && held_n < HoldDepth) begin
          hold_byte(c);
          phase = PH_HEX;
          num_val = 17'(d);
          dig_n = 1;
        end else begin
          miss(c);
        end
      end
      PH_HEX: begin
        if (d >= 0 && dig_n < MaxHex && held_n < HoldDepth) begin
          hold_byte(c);
          num_val = 17'({num_val, 4'(d)});
          dig_n++;
        end else if (c == ChSemi) begin
          v = num_val;
          drop_match();
          put_utf8(v);
        end else begin
          miss(c);
        end
      end
      default: begin
        miss(c);
      end
    endcase
  endfunction

  function automatic void decode_byte(xmleu_in_t w);
    int last_i;
    emit_b.delete();
    take_byte(w.text_byte);
    if (w.stream_last) begin
      release_held();
      drop_match();
    end
    last_i = emit_b.size() - 1;
    if (emit_b.size() == 0) begin
      if (w.stream_last) begin
        decoded_q.push_back('{out_byte: 8'h00, byte_present: 1'b0, run_end: 1'b1,
                              text_end: 1'b1});
      end
    end else begin
      foreach (emit_b[i]) begin
        decoded_q.push_back('{out_byte: emit_b[i], byte_present: 1'b1,
                              run_end: (i == last_i),
                              text_end: (i == last_i) && w.stream_last});
      end
    end
  endfunction

  function automatic void cmp_field(string f, logic [7:0] e, logic [7:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, f, e, a);
      n_errors++;
    end
  endfunction

  function automatic void check_word(xmleu_out_t w);
    xmleu_out_t e;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected word, expected none, got %h/%b/%b/%b", $time,
               w.out_byte, w.byte_present, w.run_end, w.text_end);
      n_errors++;
      return;
    end
    e = decoded_q.pop_front();
    n_words++;
    if (w.text_end === 1'b1) n_texts++;
    cmp_field("out_byte", e.out_byte, w.out_byte);
    cmp_field("byte_present", 8'(e.byte_present), 8'(w.byte_present));
    cmp_field("run_end", 8'(e.run_end), 8'(w.run_end));
    cmp_field("text_end", 8'(e.text_end), 8'(w.text_end));
  endfunction

  // mostly short gaps, a few long ones, now and then a run with none
  function automatic int idle_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_data);
        n_bytes++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (text_q.size() > 0) begin
          in_data <= text_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= idle_len(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_word(out_data);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= idle_len(out_burst);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", n_cycles,
               decoded_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) frag.push_back(s[i]);
  endtask

  task automatic dump_frag(bit rnd_last);
    foreach (frag[i]) begin
      text_q.push_back('{text_byte: frag[i],
                         stream_last: rnd_last && ($urandom_range(0, 24) == 0)});
    end
    frag.delete();
  endtask

  task automatic mark_last();
    xmleu_in_t w;
    w = text_q.pop_back();
    w.stream_last = 1'b1;
    text_q.push_back(w);
  endtask

  task automatic add_fragment();
    int kind;
    int v;
    int cut;
    string digs;
    string specials;
    specials = "&#x;9aF<";
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      add_str({"&", ent_names[$urandom_range(0, 4)]});
    end else if (kind < 4) begin
      case ($urandom_range(0, 6))
        0: v = $urandom_range(1, 127);
        1: v = $urandom_range(128, 2047);
        2: v = $urandom_range(2048, 65535);
        3: v = $urandom_range(55296, 57343);
        4: v = $urandom_range(65536, 99999);
        5: v = 0;
        default: v = $urandom_range(100000, 999999);
      endcase
      if ($urandom_range(0, 3) == 0) add_str($sformatf("&#%05d;", v));
      else add_str($sformatf("&#%0d;", v));
    end else if (kind < 6) begin
      case ($urandom_range(0, 6))
        0: v = $urandom_range(1, 'h7f);
        1: v = $urandom_range('h80, 'h7ff);
        2: v = $urandom_range('h800, 'hffff);
        3: v = $urandom_range('hd800, 'hdfff);
        4: v = 0;
        default: v = $urandom_range('h10000, 'hfffff);
      endcase
      if ($urandom_range(0, 3) == 0) digs = $sformatf("%04h", v);
      else digs = $sformatf("%0h", v);
      for (int i = 0; i < digs.len(); i++) begin
        if (digs[i] >= "a" && digs[i] <= "f" && $urandom_range(0, 1) == 1) begin
          digs[i] = digs[i] - 8'h20;
        end
      end
      // uppercase marker is not a hex reference
      if ($urandom_range(0, 7) == 0) add_str({"&#X", digs, ";"});
      else add_str({"&#x", digs, ";"});
    end else if (kind < 9) begin
      frag.push_back(8'($urandom_range(0, 255)));
    end else begin
      frag.push_back(specials[$urandom_range(0, specials.len() - 1)]);
    end
    // broken sequence: cut short and followed by a stray byte
    if (frag.size() > 1 && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, frag.size() - 1);
      while (frag.size() > cut) void'(frag.pop_back());
      if ($urandom_range(0, 1) == 1) frag.push_back(ChAmp);
      else frag.push_back(8'($urandom_range(0, 255)));
    end
    dump_frag(1'b1);
  endtask

  initial begin
    int n_directed;
    frag.push_back(8'h00);
    frag.push_back(8'hff);
    dump_frag(1'b0);
    mark_last();
    add_str("&gt;&&#65;&#70000;&#xFFFF;");
    dump_frag(1'b0);
    add_str("&#0;");
    dump_frag(1'b0);
    mark_last();
    add_str("&q");
    dump_frag(1'b0);
    mark_last();
    n_directed = text_q.size();
    while (text_q.size() < n_directed + NumRandom) add_fragment();
    mark_last();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (40) @(posedge clk_i);

    $display("%0d text bytes sent, %0d decoded words checked over %0d text streams",
             n_bytes, n_words, n_texts);
    $display("named and numeric references, broken matches and stream ends, with stalls");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/xmleu_pkg.sv
hw/rtl/xmleu_decode.sv
hw/rtl/xml_entity_unescape.sv
test/tb_top.sv
